@@ rtl/qwpc_pkg.sv @@
package qwpc_pkg;

  // Default sizes of the server set and the quorum table
  localparam int SERVERS_DEF = 8;
  localparam int QUORUMS_DEF = 8;

  // Fixed field widths
  localparam int MEMBER_W   = 8;
  localparam int REQ_W      = 16;
  localparam int TS_W       = 32;
  localparam int WR_W       = 8;
  localparam int VAL_W      = 32;
  localparam int SRV_W      = 3;
  localparam int QIDX_W     = 3;
  localparam int QCNT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WRITER_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUORUM_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMBERSHIP   = 2'd2;

  // Input commands and result kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_REPLY = 1'b1;
  localparam logic KIND_MSG  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // One stored server reply
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [TS_W-1:0]  ts;
    logic [WR_W-1:0]  writer;
    logic [VAL_W-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam slot_t SLOT_RESET = '{req: '0, ts: '0, writer: '0, value: '1};

endpackage

@@ rtl/qwpc_in_if.sv @@
interface qwpc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic                             is_write;
  logic signed [qwpc_pkg::VAL_W-1:0] write_value;
  logic [qwpc_pkg::SRV_W-1:0]       server;
  logic [qwpc_pkg::REQ_W-1:0]       reply_request;
  logic [qwpc_pkg::TS_W-1:0]        reply_ts;
  logic [qwpc_pkg::WR_W-1:0]        reply_writer;
  logic signed [qwpc_pkg::VAL_W-1:0] reply_value;

  modport source (
    output valid, cmd, is_write, write_value, server, reply_request, reply_ts,
           reply_writer, reply_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, is_write, write_value, server, reply_request, reply_ts,
           reply_writer, reply_value,
    output ready
  );
endinterface

@@ rtl/qwpc_out_if.sv @@
interface qwpc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [qwpc_pkg::REQ_W-1:0]        request_number;
  logic [qwpc_pkg::TS_W-1:0]         tag_ts;
  logic [qwpc_pkg::WR_W-1:0]         tag_writer;
  logic signed [qwpc_pkg::VAL_W-1:0] obj_value;
  logic [qwpc_pkg::QIDX_W-1:0]       quorum_index;

  modport source (
    output valid, kind, request_number, tag_ts, tag_writer, obj_value, quorum_index,
    input  ready
  );
  modport sink (
    input  valid, kind, request_number, tag_ts, tag_writer, obj_value, quorum_index,
    output ready
  );
endinterface

@@ rtl/quorum_write_phase_collector.sv @@
// Start item: the message goes to the emit state and then into the output register once it is free.
// Reply that completes a quorum: the tag search reads the server slot memory one entry per cycle,
// then the result goes to the emit state and into the output register once it is free.
// Other replies produce no result. One item is worked on at a time; the next transfer is taken
// once the previous item has reached the output register.
// Synchronous active-low reset; slot entries read as reset values until first written.
module quorum_write_phase_collector #(
  parameter int SERVERS = qwpc_pkg::SERVERS_DEF,
  parameter int QUORUMS = qwpc_pkg::QUORUMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  qwpc_in_if.sink                             in_chan,
  qwpc_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [qwpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qwpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int AW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CW = $clog2(SERVERS + 1);
  localparam int MW = qwpc_pkg::MEMBER_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  // Control and configuration
  state_t                          state_r, state_nxt;
  logic [qwpc_pkg::WR_W-1:0]       writer_id_r, writer_id_nxt;
  logic [qwpc_pkg::QCNT_W-1:0]     qcount_r, qcount_nxt;
  logic [qwpc_pkg::CFG_DATA_W-1:0] membership_r, membership_nxt;
  logic [qwpc_pkg::REQ_W-1:0]      req_cnt_r, req_cnt_nxt;
  logic [qwpc_pkg::TS_W-1:0]       msg_ts_r, msg_ts_nxt;
  logic [qwpc_pkg::VAL_W-1:0]      msg_val_r, msg_val_nxt;
  logic [qwpc_pkg::TS_W-1:0]       last_max_r, last_max_nxt;
  logic                            phase_r, phase_nxt;
  logic [MW-1:0]                   ack_r, ack_nxt;
  logic [SERVERS-1:0]              valid_r, valid_nxt;
  logic                            res_kind_r, res_kind_nxt;

  // Tag search
  logic [qwpc_pkg::QIDX_W-1:0]     qsel_r, qsel_nxt;
  logic [MW-1:0]                   qmem_r, qmem_nxt;
  logic [CW-1:0]                   rd_cnt_r, rd_cnt_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic                            rd_ok_r, rd_ok_nxt;
  logic [qwpc_pkg::TS_W-1:0]       best_ts_r, best_ts_nxt;
  logic [qwpc_pkg::WR_W-1:0]       best_wr_r, best_wr_nxt;
  logic [qwpc_pkg::REQ_W-1:0]      best_req_r, best_req_nxt;
  logic [qwpc_pkg::VAL_W-1:0]      best_val_r, best_val_nxt;

  // Output register
  logic                            o_valid_r, o_valid_nxt;
  logic                            o_kind_r, o_kind_nxt;
  logic [qwpc_pkg::REQ_W-1:0]      o_req_r, o_req_nxt;
  logic [qwpc_pkg::TS_W-1:0]       o_ts_r, o_ts_nxt;
  logic [qwpc_pkg::WR_W-1:0]       o_wr_r, o_wr_nxt;
  logic [qwpc_pkg::VAL_W-1:0]      o_val_r, o_val_nxt;
  logic [qwpc_pkg::QIDX_W-1:0]     o_qidx_r, o_qidx_nxt;

  // Memory ports
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  qwpc_pkg::slot_t                 ram_wdata;
  logic [qwpc_pkg::SLOT_W-1:0]     ram_rdata;

  // Decode helpers
  logic                            in_xfer;
  logic                            srv_ok;
  logic                            reply_match;
  logic [MW-1:0]                   ack_new;
  logic                            q_found;
  logic [qwpc_pkg::QIDX_W-1:0]     q_idx;
  logic [MW-1:0]                   q_mem;
  qwpc_pkg::slot_t                 rd_slot;
  logic                            cand_take;
  logic [qwpc_pkg::TS_W-1:0]       cur_ts;
  logic [qwpc_pkg::WR_W-1:0]       cur_wr;

  qwpc_ram #(
    .WIDTH (qwpc_pkg::SLOT_W),
    .DEPTH (SERVERS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid          = o_valid_r;
  assign out_chan.kind           = o_kind_r;
  assign out_chan.request_number = o_req_r;
  assign out_chan.tag_ts         = o_ts_r;
  assign out_chan.tag_writer     = o_wr_r;
  assign out_chan.obj_value      = o_val_r;
  assign out_chan.quorum_index   = o_qidx_r;

  // Reply decode: range check, request match and the updated ack set
  assign srv_ok      = ({1'b0, in_chan.server} < (qwpc_pkg::SRV_W + 1)'(SERVERS));
  assign reply_match = (in_chan.reply_request == req_cnt_r);
  assign ack_new     = ack_r | ({{(MW-1){1'b0}}, reply_match} << in_chan.server);

  assign ram_we    = in_xfer && (in_chan.cmd == qwpc_pkg::CMD_REPLY) && srv_ok;
  assign ram_waddr = in_chan.server[AW-1:0];
  assign ram_wdata = '{req: in_chan.reply_request, ts: in_chan.reply_ts,
                       writer: in_chan.reply_writer, value: in_chan.reply_value};
  assign ram_raddr = rd_cnt_r[AW-1:0];

  // Pick the first complete, non-empty quorum in use
  always_comb begin
    logic [MW-1:0] mem;
    q_found = 1'b0;
    q_idx   = '0;
    q_mem   = '0;
    for (int q = 0; q < MW; q++) begin
      mem = membership_r[q*MW +: MW];
      if (q < QUORUMS && qwpc_pkg::QCNT_W'(q) < qcount_r && !q_found &&
          mem != '0 && (mem & ~ack_new) == '0) begin
        q_found = 1'b1;
        q_idx   = qwpc_pkg::QIDX_W'(q);
        q_mem   = mem;
      end
    end
  end

  // Compare the returned slot against the best tag so far
  assign rd_slot   = rd_ok_r ? qwpc_pkg::slot_t'(ram_rdata) : qwpc_pkg::SLOT_RESET;
  assign cur_ts    = best_ts_r;
  assign cur_wr    = best_wr_r;
  assign cand_take = qmem_r[rd_idx_r] && (rd_slot.req == req_cnt_r) &&
                     ((rd_slot.ts > cur_ts) ||
                      (rd_slot.ts == cur_ts && rd_slot.writer > cur_wr));

  always_comb begin
    state_nxt      = state_r;
    writer_id_nxt  = writer_id_r;
    qcount_nxt     = qcount_r;
    membership_nxt = membership_r;
    req_cnt_nxt    = req_cnt_r;
    msg_ts_nxt     = msg_ts_r;
    msg_val_nxt    = msg_val_r;
    last_max_nxt   = last_max_r;
    phase_nxt      = phase_r;
    ack_nxt        = ack_r;
    valid_nxt      = valid_r;
    res_kind_nxt   = res_kind_r;
    qsel_nxt       = qsel_r;
    qmem_nxt       = qmem_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    rd_ok_nxt      = rd_ok_r;
    best_ts_nxt    = best_ts_r;
    best_wr_nxt    = best_wr_r;
    best_req_nxt   = best_req_r;
    best_val_nxt   = best_val_r;
    o_valid_nxt    = o_valid_r && !out_chan.ready;
    o_kind_nxt     = o_kind_r;
    o_req_nxt      = o_req_r;
    o_ts_nxt       = o_ts_r;
    o_wr_nxt       = o_wr_r;
    o_val_nxt      = o_val_r;
    o_qidx_nxt     = o_qidx_r;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        qwpc_pkg::CFG_WRITER_ID:    writer_id_nxt  = cfg_data[qwpc_pkg::WR_W-1:0];
        qwpc_pkg::CFG_QUORUM_COUNT: qcount_nxt     = cfg_data[qwpc_pkg::QCNT_W-1:0];
        qwpc_pkg::CFG_MEMBERSHIP:   membership_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.cmd == qwpc_pkg::CMD_START) begin
            // Open a phase and queue the message
            req_cnt_nxt  = req_cnt_r + 1'b1;
            if (in_chan.is_write) begin
              msg_ts_nxt  = last_max_r + 1'b1;
              msg_val_nxt = in_chan.write_value;
            end
            phase_nxt    = 1'b1;
            ack_nxt      = '0;
            res_kind_nxt = qwpc_pkg::KIND_MSG;
            state_nxt    = ST_EMIT;
          end else if (srv_ok) begin
            // Store the reply, record its ack, start the tag search on completion
            valid_nxt[in_chan.server[AW-1:0]] = 1'b1;
            ack_nxt = ack_new;
            if (phase_r && q_found) begin
              qsel_nxt     = q_idx;
              qmem_nxt     = q_mem;
              rd_cnt_nxt   = '0;
              best_ts_nxt  = '0;
              best_wr_nxt  = '0;
              res_kind_nxt = qwpc_pkg::KIND_DONE;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // Issue one slot read per cycle
        if (rd_cnt_r < CW'(SERVERS)) begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = rd_cnt_r[AW-1:0];
          rd_ok_nxt   = valid_r[rd_cnt_r[AW-1:0]];
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
        end
        // Fold returned slot into the best tag; slot 0 sets the fallback
        if (rd_pend_r) begin
          if (rd_idx_r == '0) begin
            best_req_nxt = rd_slot.req;
            best_val_nxt = rd_slot.value;
          end
          if (cand_take) begin
            best_ts_nxt  = rd_slot.ts;
            best_wr_nxt  = rd_slot.writer;
            best_req_nxt = rd_slot.req;
            best_val_nxt = rd_slot.value;
          end
          if (rd_idx_r == AW'(SERVERS - 1)) begin
            last_max_nxt = best_ts_nxt;
            ack_nxt      = '0;
            phase_nxt    = 1'b0;
            state_nxt    = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        // Load the output register once it is free
        if (!o_valid_r || out_chan.ready) begin
          o_valid_nxt = 1'b1;
          o_kind_nxt  = res_kind_r;
          if (res_kind_r == qwpc_pkg::KIND_MSG) begin
            o_req_nxt  = req_cnt_r;
            o_ts_nxt   = msg_ts_r;
            o_wr_nxt   = writer_id_r;
            o_val_nxt  = msg_val_r;
            o_qidx_nxt = '0;
          end else begin
            o_req_nxt  = best_req_r;
            o_ts_nxt   = best_ts_r;
            o_wr_nxt   = best_wr_r;
            o_val_nxt  = best_val_r;
            o_qidx_nxt = qsel_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      writer_id_r  <= '0;
      qcount_r     <= '0;
      membership_r <= '0;
      req_cnt_r    <= '0;
      msg_ts_r     <= '0;
      msg_val_r    <= '1;
      last_max_r   <= '0;
      phase_r      <= 1'b0;
      ack_r        <= '0;
      valid_r      <= '0;
      rd_cnt_r     <= '0;
      rd_pend_r    <= 1'b0;
      o_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      writer_id_r  <= writer_id_nxt;
      qcount_r     <= qcount_nxt;
      membership_r <= membership_nxt;
      req_cnt_r    <= req_cnt_nxt;
      msg_ts_r     <= msg_ts_nxt;
      msg_val_r    <= msg_val_nxt;
      last_max_r   <= last_max_nxt;
      phase_r      <= phase_nxt;
      ack_r        <= ack_nxt;
      valid_r      <= valid_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      o_valid_r    <= o_valid_nxt;
    end
    res_kind_r <= res_kind_nxt;
    qsel_r     <= qsel_nxt;
    qmem_r     <= qmem_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_ok_r    <= rd_ok_nxt;
    best_ts_r  <= best_ts_nxt;
    best_wr_r  <= best_wr_nxt;
    best_req_r <= best_req_nxt;
    best_val_r <= best_val_nxt;
    o_kind_r   <= o_kind_nxt;
    o_req_r    <= o_req_nxt;
    o_ts_r     <= o_ts_nxt;
    o_wr_r     <= o_wr_nxt;
    o_val_r    <= o_val_nxt;
    o_qidx_r   <= o_qidx_nxt;
  end

  // Acks only ever name servers that exist
  a_ack_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ack_r >> SERVERS) == '0)
    else $error("ack set for a server beyond the configured set");

  // A completed quorum has already closed its phase
  a_done_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && res_kind_r == qwpc_pkg::KIND_DONE) |-> (!phase_r && ack_r == '0))
    else $error("quorum result pending while phase still open");

  // Slot read data only returns during the tag search
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SCAN))
    else $error("slot read returned outside the tag search");

  // A start transfer bumps the request counter by one
  a_start_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_chan.cmd == qwpc_pkg::CMD_START) |=>
      (req_cnt_r == qwpc_pkg::REQ_W'($past(req_cnt_r) + 1'b1)))
    else $error("request counter not advanced by start");

endmodule

@@ rtl/qwpc_ram.sv @@
module qwpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ dv/quorum_write_phase_collector_test.sv @@
`timescale 1ns / 1ps

module quorum_write_phase_collector_test;

  typedef struct packed {
    logic                               cmd;
    logic                               is_write;
    logic signed [qwpc_pkg::VAL_W-1:0]  write_value;
    logic [qwpc_pkg::SRV_W-1:0]         server;
    logic [qwpc_pkg::REQ_W-1:0]         reply_request;
    logic [qwpc_pkg::TS_W-1:0]          reply_ts;
    logic [qwpc_pkg::WR_W-1:0]          reply_writer;
    logic signed [qwpc_pkg::VAL_W-1:0]  reply_value;
  } phase_item_t;

  typedef struct packed {
    logic                               kind;
    logic [qwpc_pkg::REQ_W-1:0]         request_number;
    logic [qwpc_pkg::TS_W-1:0]          tag_ts;
    logic [qwpc_pkg::WR_W-1:0]          tag_writer;
    logic signed [qwpc_pkg::VAL_W-1:0]  obj_value;
    logic [qwpc_pkg::QIDX_W-1:0]        quorum_index;
  } collector_result_t;

  typedef struct packed {
    phase_item_t       item;
    logic              typed;
    collector_result_t want;
  } directed_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [qwpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qwpc_pkg::CFG_DATA_W-1:0] cfg_data;

  qwpc_in_if  in_ch ();
  qwpc_out_if out_ch ();

  quorum_write_phase_collector i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predicted collector state and its copy of the registers
  logic [qwpc_pkg::REQ_W-1:0]        req_num;
  logic [qwpc_pkg::TS_W-1:0]         msg_ts;
  logic signed [qwpc_pkg::VAL_W-1:0] msg_val;
  logic [qwpc_pkg::TS_W-1:0]         top_ts;
  logic                              phase_open;
  logic [7:0]                        acked;
  qwpc_pkg::slot_t                   slots [qwpc_pkg::SERVERS_DEF];
  logic [qwpc_pkg::WR_W-1:0]         my_writer;
  logic [qwpc_pkg::QCNT_W-1:0]       quorums_used;
  logic [63:0]                       member_map;

  collector_result_t pending_results [$];
  idle_mode_t        idle_mode = IDLE_NONE;
  int                items_sent = 0;
  int                fail_count = 0;
  logic              hold_go = 1'b0;
  logic              hold_off = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the result of one accepted item and advance the predicted state
  function automatic logic predict_collector(input phase_item_t it,
                                             output collector_result_t r);
    int                        q;
    int                        s;
    int                        nq;
    int                        pos;
    logic [7:0]                mem;
    logic [qwpc_pkg::TS_W-1:0] best_ts;
    logic [qwpc_pkg::WR_W-1:0] best_wr;
    r = '0;
    if (it.cmd == qwpc_pkg::CMD_START) begin
      req_num = req_num + 1'b1;
      if (it.is_write) begin
        msg_ts  = top_ts + 1'b1;
        msg_val = it.write_value;
      end
      phase_open       = 1'b1;
      acked            = '0;
      r.kind           = qwpc_pkg::KIND_MSG;
      r.request_number = req_num;
      r.tag_ts         = msg_ts;
      r.tag_writer     = my_writer;
      r.obj_value      = msg_val;
      return 1'b1;
    end
    slots[it.server] = '{req: it.reply_request, ts: it.reply_ts,
                         writer: it.reply_writer, value: it.reply_value};
    if (it.reply_request == req_num) acked[it.server] = 1'b1;
    if (!phase_open) return 1'b0;
    nq = (quorums_used > qwpc_pkg::QUORUMS_DEF) ? qwpc_pkg::QUORUMS_DEF : quorums_used;
    // first quorum, in order, that is non-empty and fully acked wins
    for (q = 0; q < nq; q++) begin
      mem = member_map[8*q +: 8];
      if (mem == '0 || (mem & ~acked) != '0) continue;
      best_ts = '0;
      best_wr = '0;
      pos     = 0;
      for (s = 0; s < qwpc_pkg::SERVERS_DEF; s++) begin
        if (mem[s] && slots[s].req == req_num &&
            (slots[s].ts > best_ts ||
             (slots[s].ts == best_ts && slots[s].writer > best_wr))) begin
          best_ts = slots[s].ts;
          best_wr = slots[s].writer;
          pos     = s;
        end
      end
      top_ts           = best_ts;
      acked            = '0;
      phase_open       = 1'b0;
      r.kind           = qwpc_pkg::KIND_DONE;
      r.request_number = slots[pos].req;
      r.tag_ts         = best_ts;
      r.tag_writer     = best_wr;
      r.obj_value      = slots[pos].value;
      r.quorum_index   = qwpc_pkg::QIDX_W'(q);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic phase_item_t start_item(input logic wr,
                                             input logic [qwpc_pkg::VAL_W-1:0] value);
    phase_item_t it;
    it.cmd           = qwpc_pkg::CMD_START;
    it.is_write      = wr;
    it.write_value   = value;
    it.server        = qwpc_pkg::SRV_W'($urandom_range(0, 7));
    it.reply_request = qwpc_pkg::REQ_W'($urandom);
    it.reply_ts      = $urandom;
    it.reply_writer  = qwpc_pkg::WR_W'($urandom);
    it.reply_value   = $urandom;
    return it;
  endfunction

  function automatic phase_item_t reply_item(input logic [qwpc_pkg::SRV_W-1:0] srv,
                                             input logic [qwpc_pkg::REQ_W-1:0] rq,
                                             input logic [qwpc_pkg::TS_W-1:0] ts,
                                             input logic [qwpc_pkg::WR_W-1:0] wr,
                                             input logic [qwpc_pkg::VAL_W-1:0] value);
    phase_item_t it;
    it.cmd           = qwpc_pkg::CMD_REPLY;
    it.is_write      = 1'($urandom_range(0, 1));
    it.write_value   = $urandom;
    it.server        = srv;
    it.reply_request = rq;
    it.reply_ts      = ts;
    it.reply_writer  = wr;
    it.reply_value   = value;
    return it;
  endfunction

  function automatic collector_result_t known_result(
      input logic                        kind,
      input logic [qwpc_pkg::REQ_W-1:0]  rq,
      input logic [qwpc_pkg::TS_W-1:0]   ts,
      input logic [qwpc_pkg::WR_W-1:0]   wr,
      input logic [qwpc_pkg::VAL_W-1:0]  value,
      input logic [qwpc_pkg::QIDX_W-1:0] q);
    collector_result_t r;
    r.kind           = kind;
    r.request_number = rq;
    r.tag_ts         = ts;
    r.tag_writer     = wr;
    r.obj_value      = value;
    r.quorum_index   = q;
    return r;
  endfunction

  // Reply aimed mostly at one quorum's members, mostly with the current request
  function automatic phase_item_t random_reply(input logic [7:0] aim);
    logic [qwpc_pkg::SRV_W-1:0] srv;
    logic [qwpc_pkg::REQ_W-1:0] rq;
    logic [qwpc_pkg::TS_W-1:0]  ts;
    logic [qwpc_pkg::WR_W-1:0]  wr;
    srv = qwpc_pkg::SRV_W'($urandom_range(0, 7));
    if (aim != '0 && $urandom_range(0, 4) != 0) begin
      while (!aim[srv]) srv = qwpc_pkg::SRV_W'($urandom_range(0, 7));
    end
    rq = ($urandom_range(0, 7) != 0) ? req_num : qwpc_pkg::REQ_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0, 1: ts = $urandom_range(0, 2);
      2: ts = top_ts + $urandom_range(0, 1);
      default: ts = $urandom;
    endcase
    wr = $urandom_range(0, 1) ? qwpc_pkg::WR_W'($urandom_range(0, 2))
                              : qwpc_pkg::WR_W'($urandom_range(0, 255));
    return reply_item(srv, rq, ts, wr, $urandom);
  endfunction

  function automatic logic [63:0] random_membership();
    logic [63:0] m;
    int          q;
    for (q = 0; q < qwpc_pkg::QUORUMS_DEF; q++) begin
      case ($urandom_range(0, 9))
        0: m[8*q +: 8] = 8'h00;
        1: m[8*q +: 8] = 8'hFF;
        2, 3, 4: m[8*q +: 8] = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
        default: m[8*q +: 8] = 8'($urandom_range(1, 255));
      endcase
    end
    return m;
  endfunction

  function automatic logic idles(input logic rx);
    case (idle_mode)
      IDLE_SENDER:   return !rx && $urandom_range(0, 99) < 81;
      IDLE_RECEIVER: return rx && $urandom_range(0, 99) < 81;
      IDLE_BOTH:     return $urandom_range(0, 99) < 22;
      default:       return 1'b0;
    endcase
  endfunction

  // Offer one item, hold it until the transfer, then queue what it should produce
  task automatic offer(input phase_item_t it, input logic typed, input collector_result_t want);
    collector_result_t r;
    while (idles(1'b0)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= it.cmd;
    in_ch.is_write      <= it.is_write;
    in_ch.write_value   <= it.write_value;
    in_ch.server        <= it.server;
    in_ch.reply_request <= it.reply_request;
    in_ch.reply_ts      <= it.reply_ts;
    in_ch.reply_writer  <= it.reply_writer;
    in_ch.reply_value   <= it.reply_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_collector(it, r)) pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic write_config(input logic [qwpc_pkg::WR_W-1:0] wid,
                              input logic [qwpc_pkg::QCNT_W-1:0] qc,
                              input logic [63:0] mem);
    cfg_we    <= 1'b1;
    cfg_index <= qwpc_pkg::CFG_WRITER_ID;
    cfg_data  <= {56'd0, wid};
    @(posedge clk);
    cfg_index <= qwpc_pkg::CFG_QUORUM_COUNT;
    cfg_data  <= {60'd0, qc};
    @(posedge clk);
    cfg_index <= qwpc_pkg::CFG_MEMBERSHIP;
    cfg_data  <= mem;
    @(posedge clk);
    cfg_we       <= 1'b0;
    my_writer    = wid;
    quorums_used = qc;
    member_map   = mem;
  endtask

  // Drain all results, then let any quorum search still in progress run out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (qwpc_pkg::SERVERS_DEF + 8) @(posedge clk);
  endtask

  // One phase: optional stray replies, a start, then replies until a quorum closes or a reply cap is reached
  task automatic run_round();
    logic [7:0] aim;
    int         cap;
    int         n;
    int         nq;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) offer(random_reply(8'h00), 1'b0, '0);
    end
    offer(start_item(1'($urandom_range(0, 1)), $urandom), 1'b0, '0);
    nq  = (quorums_used > qwpc_pkg::QUORUMS_DEF) ? qwpc_pkg::QUORUMS_DEF : quorums_used;
    aim = (nq == 0) ? 8'h00 : member_map[8*$urandom_range(0, nq - 1) +: 8];
    cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 24;
    for (n = 0; n < cap && phase_open; n++) offer(random_reply(aim), 1'b0, '0);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request
  always @(posedge clk) out_ch.ready <= !hold_off && !idles(1'b1);

  initial begin : receiver_hold
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Compare each result transfer with the oldest outstanding prediction
  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    collector_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 64'(want.kind), 64'(out_ch.kind));
        compare_field("request_number", 64'(want.request_number),
                      64'(out_ch.request_number));
        compare_field("tag_ts", 64'(want.tag_ts), 64'(out_ch.tag_ts));
        compare_field("tag_writer", 64'(want.tag_writer), 64'(out_ch.tag_writer));
        compare_field("obj_value", 64'(want.obj_value), 64'(out_ch.obj_value));
        compare_field("quorum_index", 64'(want.quorum_index), 64'(out_ch.quorum_index));
      end
    end
  end

  initial begin : stimulus
    directed_row_t plan [20];
    int            p;
    int            phase_end;
    int            i;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = qwpc_pkg::CFG_WRITER_ID;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = qwpc_pkg::CMD_START;
    in_ch.is_write      = 1'b0;
    in_ch.write_value   = '0;
    in_ch.server        = '0;
    in_ch.reply_request = '0;
    in_ch.reply_ts      = '0;
    in_ch.reply_writer  = '0;
    in_ch.reply_value   = '0;

    req_num      = '0;
    msg_ts       = '0;
    msg_val      = '1;
    top_ts       = '0;
    phase_open   = 1'b0;
    acked        = '0;
    my_writer    = '0;
    quorums_used = '0;
    member_map   = '0;
    foreach (slots[s]) slots[s] = qwpc_pkg::SLOT_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Quorum 0 empty, quorum 1 = {1,2}, quorum 2 = {0,7}, quorum 3 = everyone
    write_config(8'hFF, 4'd4, 64'h0000_0000_FF81_0600);

    plan = '{
      // reply with no phase open: stored and acked, nothing emitted
      '{reply_item(3'd3, 16'd0, 32'd5, 8'd1, 32'd7), 1'b0, '0},
      // first read phase carries the reset timestamp and value
      '{start_item(1'b0, 32'd0), 1'b1,
        known_result(qwpc_pkg::KIND_MSG, 16'd1, 32'd0, 8'hFF, 32'hFFFF_FFFF, 3'd0)},
      '{reply_item(3'd1, 16'd1, 32'hFFFF_FFFF, 8'h00, 32'h7FFF_FFFF), 1'b0, '0},
      // wrong request number: slot overwritten, no ack
      '{reply_item(3'd2, 16'd2, 32'd9, 8'd5, 32'd5), 1'b0, '0},
      '{reply_item(3'd2, 16'd1, 32'd3, 8'hFF, 32'h8000_0000), 1'b1,
        known_result(qwpc_pkg::KIND_DONE, 16'd1, 32'hFFFF_FFFF, 8'h00, 32'h7FFF_FFFF, 3'd1)},
      // timestamp wraps past the all-ones maximum
      '{start_item(1'b1, 32'h1234_5678), 1'b1,
        known_result(qwpc_pkg::KIND_MSG, 16'd2, 32'd0, 8'hFF, 32'h1234_5678, 3'd0)},
      // start while a phase is open; read keeps the last message
      '{start_item(1'b0, 32'hDEAD_BEEF), 1'b1,
        known_result(qwpc_pkg::KIND_MSG, 16'd3, 32'd0, 8'hFF, 32'h1234_5678, 3'd0)},
      '{reply_item(3'd0, 16'd3, 32'd0, 8'd0, 32'd11), 1'b0, '0},
      // mismatch after an ack: slot changes, ack stays set
      '{reply_item(3'd0, 16'd9, 32'd100, 8'd3, 32'd22), 1'b0, '0},
      // no matching tag above zero: value and request come from slot 0
      '{reply_item(3'd7, 16'd3, 32'd0, 8'd0, 32'd33), 1'b1,
        known_result(qwpc_pkg::KIND_DONE, 16'd9, 32'd0, 8'h00, 32'd22, 3'd2)},
      '{reply_item(3'd4, 16'd3, 32'd7, 8'd7, 32'd44), 1'b0, '0},
      '{start_item(1'b1, 32'h8000_0000), 1'b1,
        known_result(qwpc_pkg::KIND_MSG, 16'd4, 32'd1, 8'hFF, 32'h8000_0000, 3'd0)},
      // equal timestamps: the larger writer id wins
      '{reply_item(3'd1, 16'd4, 32'd50, 8'd10, 32'd55), 1'b0, '0},
      '{reply_item(3'd2, 16'd4, 32'd50, 8'd200, 32'd66), 1'b0, '0},
      '{start_item(1'b0, 32'd0), 1'b0, '0},
      '{reply_item(3'd7, 16'd5, 32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFFF), 1'b0, '0},
      '{reply_item(3'd0, 16'd5, 32'hFFFF_FFFF, 8'hFE, 32'd1), 1'b0, '0},
      '{start_item(1'b1, 32'd0), 1'b0, '0},
      '{reply_item(3'd1, 16'hFFFF, 32'hAAAA_5555, 8'h5A, 32'h5555_AAAA), 1'b0, '0},
      '{start_item(1'b1, 32'h7FFF_FFFF), 1'b0, '0}
    };
    for (i = 0; i < 20; i++) offer(plan[i].item, plan[i].typed, plan[i].want);

    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          idle_mode = IDLE_NONE;
          write_config(8'h00, 4'd8, '1);
        end
        1: begin
          idle_mode = IDLE_SENDER;
          write_config(8'hFF, 4'd15, random_membership());
        end
        2: begin
          idle_mode = IDLE_RECEIVER;
          write_config(8'($urandom_range(0, 255)), 4'd8, '0);
        end
        3: begin
          idle_mode = IDLE_BOTH;
          write_config(8'($urandom_range(0, 255)), 4'($urandom_range(1, 8)),
                       random_membership());
        end
        4: begin
          // back-to-back items against a long receiver hold-off
          idle_mode = IDLE_NONE;
          write_config(8'($urandom_range(0, 255)), 4'($urandom_range(1, 8)),
                       random_membership());
          hold_go = 1'b1;
        end
        default: begin
          idle_mode = IDLE_BOTH;
          write_config(8'($urandom_range(0, 255)), 4'd0, random_membership());
        end
      endcase
      phase_end = items_sent + 125;
      while (items_sent < phase_end) run_round();
    end

    settle();
    if (fail_count == 0) begin
      $display("quorum_write_phase_collector_test OK");
    end else begin
      $display("quorum_write_phase_collector_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("quorum_write_phase_collector_test NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/qwpc_pkg.sv
rtl/qwpc_in_if.sv
rtl/qwpc_out_if.sv
rtl/qwpc_ram.sv
rtl/quorum_write_phase_collector.sv
dv/quorum_write_phase_collector_test.sv
